// File: rtl/core/tlbsa_pkg.sv
package tlbsa_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PAGE_W   = 20;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_INVAL = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADD_FREE   = 3'd0,
    STS_ADD_VICTIM = 3'd1,
    STS_INVALID    = 3'd2,
    STS_MISS       = 3'd3,
    STS_FLUSHED    = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

// File: rtl/core/tlbsa_ctrl.sv
module tlbsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tlbsa_pkg::cmd_t  cmd_o
);
  import tlbsa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.commit = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/tlbsa_datapath.sv
module tlbsa_datapath #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlbsa_pkg::cmd_t                cmd_i,
  input  logic [tlbsa_pkg::MODE_W-1:0]   mode_i,
  input  logic [tlbsa_pkg::PAGE_W-1:0]   page_number_i,
  input  logic [tlbsa_pkg::FRAME_W-1:0]  frame_number_i,
  input  logic                           dirty_i,
  output logic [tlbsa_pkg::SLOT_W-1:0]   slot_o,
  output logic [tlbsa_pkg::STATUS_W-1:0] status_o
);
  import tlbsa_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = $clog2(ENTRIES + 1);

  // slot table
  logic [ENTRIES-1:0] valid_q;
  logic [PAGE_W-1:0]  page_q [ENTRIES];
  logic [FRAME_W:0]   entry_mem [ENTRIES];

  // free list
  logic [LW-1:0]      link_mem [ENTRIES];
  logic [ENTRIES-1:0] link_vld_q;
  logic [LW-1:0]      link_rd_q;
  logic               link_rd_vld_q;
  logic [LW-1:0]      head_q;
  logic [IW-1:0]      rot_q;

  // captured word
  logic [MODE_W-1:0]  mode_q;
  logic [PAGE_W-1:0]  pg_q;
  logic [FRAME_W-1:0] frame_q;
  logic               dirty_q;
  logic [ENTRIES-1:0] match_q;

  logic [SLOT_W-1:0]   slot_q;
  logic [STATUS_W-1:0] status_q;

  logic [IW-1:0]        head_idx;
  logic                 list_empty;
  logic [LW-1:0]        head_next;
  logic [IW-1:0]        rot_next;
  logic                 hit_found;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        res_idx;
  status_e              res_status;
  logic                 do_add;
  logic                 do_pop;
  logic                 do_push;
  logic                 do_flush;
  logic [SLOT_W+IW-1:0] slot_ext;

  assign head_idx   = head_q[IW-1:0];
  assign list_empty = !(head_q < LW'(ENTRIES));
  assign head_next  = link_rd_vld_q ? link_rd_q : head_q + 1'b1;
  assign rot_next   = (rot_q == IW'(ENTRIES - 1)) ? '0 : rot_q + 1'b1;

  // lowest matching slot wins
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    res_idx    = '0;
    res_status = STS_MISS;
    do_add     = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_flush   = 1'b0;
    case (mode_q)
      MODE_ADD: begin
        do_add = 1'b1;
        if (!list_empty) begin
          do_pop     = 1'b1;
          res_idx    = head_idx;
          res_status = STS_ADD_FREE;
        end else begin
          res_idx    = rot_q;
          res_status = STS_ADD_VICTIM;
        end
      end
      MODE_INVAL: begin
        if (hit_found) begin
          do_push    = 1'b1;
          res_idx    = hit_idx;
          res_status = STS_INVALID;
        end
      end
      MODE_FLUSH: begin
        do_flush   = 1'b1;
        res_status = STS_FLUSHED;
      end
      default: begin
        res_status = STS_MISS;
      end
    endcase
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q        <= mode_i;
      pg_q          <= page_number_i;
      frame_q       <= frame_number_i;
      dirty_q       <= dirty_i;
      link_rd_q     <= link_mem[head_idx];
      link_rd_vld_q <= link_vld_q[head_idx];
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid_q[i] && (page_q[i] == page_number_i);
      end
    end
    if (cmd_i.commit) begin
      slot_q   <= slot_ext[SLOT_W-1:0];
      status_q <= res_status;
      if (do_add) begin
        page_q[res_idx]    <= pg_q;
        entry_mem[res_idx] <= {dirty_q, frame_q};
      end
      if (do_push) link_mem[hit_idx] <= head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      link_vld_q <= '0;
      head_q     <= '0;
      rot_q      <= '0;
    end else if (cmd_i.commit) begin
      if (do_add) begin
        valid_q[res_idx] <= 1'b1;
        if (do_pop) head_q <= head_next;
        else        rot_q  <= rot_next;
      end
      if (do_push) begin
        valid_q[hit_idx]    <= 1'b0;
        link_vld_q[hit_idx] <= 1'b1;
        head_q              <= LW'(hit_idx);
      end
      if (do_flush) begin
        valid_q    <= '0;
        link_vld_q <= '0;
        head_q     <= '0;
      end
    end
  end

  assign slot_o   = slot_q;
  assign status_o = status_q;

endmodule

// File: rtl/core/tlb_slot_allocator_top.sv
// Translation slot allocator. Each word is handled in a capture step and then a
// commit step: the accepting edge latches the word, compares its page against
// every valid slot in parallel and reads the free-list link at the head; the
// next edge at which the result register is empty or being taken picks the
// slot (lowest matching slot for an invalidate; free-list head, else the victim,
// for an add), updates table, free list and victim pointer, and loads the result
// register. While an earlier result is still stalled downstream the commit step
// waits. A new word is taken once the result is registered, even while it still
// waits downstream. The free-list links are held valid per slot, so reset and
// flush take effect at once with no clearing pass.
module tlb_slot_allocator_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlbsa_pkg::MODE_W-1:0]   mode_i,
  input  logic [tlbsa_pkg::PAGE_W-1:0]   page_number_i,
  input  logic [tlbsa_pkg::FRAME_W-1:0]  frame_number_i,
  input  logic                           dirty_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tlbsa_pkg::SLOT_W-1:0]   slot_o,
  output logic [tlbsa_pkg::STATUS_W-1:0] status_o
);
  import tlbsa_pkg::*;

  cmd_t cmd;

  tlbsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tlbsa_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .page_number_i  (page_number_i),
    .frame_number_i (frame_number_i),
    .dirty_i        (dirty_i),
    .slot_o         (slot_o),
    .status_o       (status_o)
  );

endmodule

// File: rtl/core/tlbsa_checker.sv
module tlbsa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tlbsa_pkg::SLOT_W-1:0]   slot_o,
  input logic [tlbsa_pkg::STATUS_W-1:0] status_o
);
  import tlbsa_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(status_o))
    else $error("stalled result word changed");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_MISS || status_o == STS_FLUSHED) |-> slot_o == '0)
    else $error("miss or flush reported a nonzero slot");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared with no word in flight");

endmodule

bind tlb_slot_allocator_top tlbsa_checker u_chk (.*);
